// ===== rtl/core/t16dec_pkg.sv =====
`default_nettype none
package t16dec_pkg;

   localparam logic [6:0] MN_MOVS    = 7'd0;
   localparam logic [6:0] MN_LSLS    = 7'd1;
   localparam logic [6:0] MN_LSRS    = 7'd2;
   localparam logic [6:0] MN_ASRS    = 7'd3;
   localparam logic [6:0] MN_ADDS    = 7'd4;
   localparam logic [6:0] MN_SUBS    = 7'd5;
   localparam logic [6:0] MN_CMP     = 7'd6;
   localparam logic [6:0] MN_ANDS    = 7'd7;
   localparam logic [6:0] MN_EORS    = 7'd8;
   localparam logic [6:0] MN_ADCS    = 7'd9;
   localparam logic [6:0] MN_SBCS    = 7'd10;
   localparam logic [6:0] MN_RORS    = 7'd11;
   localparam logic [6:0] MN_TST     = 7'd12;
   localparam logic [6:0] MN_RSBS    = 7'd13;
   localparam logic [6:0] MN_CMN     = 7'd14;
   localparam logic [6:0] MN_ORRS    = 7'd15;
   localparam logic [6:0] MN_MULS    = 7'd16;
   localparam logic [6:0] MN_BICS    = 7'd17;
   localparam logic [6:0] MN_MVNS    = 7'd18;
   localparam logic [6:0] MN_ADD     = 7'd19;
   localparam logic [6:0] MN_MOV     = 7'd20;
   localparam logic [6:0] MN_BLX     = 7'd21;
   localparam logic [6:0] MN_BX      = 7'd22;
   localparam logic [6:0] MN_LDR     = 7'd23;
   localparam logic [6:0] MN_STR     = 7'd24;
   localparam logic [6:0] MN_STRH    = 7'd25;
   localparam logic [6:0] MN_STRB    = 7'd26;
   localparam logic [6:0] MN_LDRSB   = 7'd27;
   localparam logic [6:0] MN_LDRH    = 7'd28;
   localparam logic [6:0] MN_LDRB    = 7'd29;
   localparam logic [6:0] MN_LDRSH   = 7'd30;
   localparam logic [6:0] MN_ADR     = 7'd31;
   localparam logic [6:0] MN_SUB     = 7'd32;
   localparam logic [6:0] MN_PUSH    = 7'd33;
   localparam logic [6:0] MN_POP     = 7'd34;
   localparam logic [6:0] MN_BKPT    = 7'd35;
   localparam logic [6:0] MN_HINT0   = 7'd36;
   localparam logic [6:0] MN_IT      = 7'd44;
   localparam logic [6:0] MN_EXT0    = 7'd45;
   localparam logic [6:0] MN_STMIA   = 7'd49;
   localparam logic [6:0] MN_LDMIA   = 7'd50;
   localparam logic [6:0] MN_UDF     = 7'd51;
   localparam logic [6:0] MN_SVC     = 7'd52;
   localparam logic [6:0] MN_B       = 7'd53;
   localparam logic [6:0] MN_UNKNOWN = 7'd54;

   localparam logic [3:0] COND_AL = 4'd14;
   localparam logic [3:0] REG_SP  = 4'd13;
   localparam logic [3:0] REG_PC  = 4'd15;

   // Decoded fields of one instruction.
   typedef struct packed {
      logic [6:0]  mnemonic;
      logic [3:0]  dest_reg;
      logic [3:0]  src_reg_a;
      logic [3:0]  src_reg_b;
      logic [9:0]  immediate;
      logic [31:0] target_addr;
      logic [8:0]  reg_list;
      logic [3:0]  cond_code;
      logic        cond_active;
      logic [2:0]  it_length;
      logic [2:0]  it_else_bits;
      logic        recognized;
   } result_type;

   // Data-processing opcode to mnemonic.
   function automatic logic [6:0] dp_code(input logic [3:0] op);
      logic [6:0] r;
      case (op)
         4'd0:  r = MN_ANDS;
         4'd1:  r = MN_EORS;
         4'd2:  r = MN_LSLS;
         4'd3:  r = MN_LSRS;
         4'd4:  r = MN_ASRS;
         4'd5:  r = MN_ADCS;
         4'd6:  r = MN_SBCS;
         4'd7:  r = MN_RORS;
         4'd8:  r = MN_TST;
         4'd9:  r = MN_RSBS;
         4'd10: r = MN_CMP;
         4'd11: r = MN_CMN;
         4'd12: r = MN_ORRS;
         4'd13: r = MN_MULS;
         4'd14: r = MN_BICS;
         default: r = MN_MVNS;
      endcase
      return r;
   endfunction

   // Register-offset load/store opcode to mnemonic.
   function automatic logic [6:0] lsreg_code(input logic [2:0] op);
      logic [6:0] r;
      case (op)
         3'd0: r = MN_STR;
         3'd1: r = MN_STRH;
         3'd2: r = MN_STRB;
         3'd3: r = MN_LDRSB;
         3'd4: r = MN_LDR;
         3'd5: r = MN_LDRH;
         3'd6: r = MN_LDRB;
         default: r = MN_LDRSH;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/t16dec_decode.sv =====
`default_nettype none
module t16dec_decode (
   input  wire logic [15:0]            hw,
   input  wire logic [31:0]            pc,
   input  wire logic [7:0]             it_state,
   output t16dec_pkg::result_type      res,
   output logic                        is_it
);
   import t16dec_pkg::*;

   logic        active;
   logic [31:0] lit;
   logic [31:0] pc4;
   logic [4:0]  imm5;
   logic [3:0]  fc;
   logic [3:0]  mask;

   assign active = (it_state[3:0] != 4'd0);
   assign pc4    = pc + 32'd4;
   assign lit    = {pc[31:2], 2'b00} + 32'd4 + {22'd0, hw[7:0], 2'b00};
   assign imm5   = hw[10:6];
   assign fc     = hw[7:4];
   assign mask   = hw[3:0];

   // One pass over the encoding classes in priority order.
   always_comb begin
      res              = '0;
      res.mnemonic     = MN_UNKNOWN;
      res.recognized   = 1'b1;
      res.cond_active  = active;
      res.cond_code    = active ? it_state[7:4] : COND_AL;
      is_it            = 1'b0;
      if (hw[15:13] == 3'b000) begin
         res.dest_reg  = {1'b0, hw[2:0]};
         res.src_reg_a = {1'b0, hw[5:3]};
         if (hw[12:11] == 2'b00) begin
            res.mnemonic  = (imm5 != 5'd0) ? MN_LSLS : MN_MOVS;
            res.immediate = {5'd0, imm5};
         end else if (hw[12:11] != 2'b11) begin
            res.mnemonic  = hw[12] ? MN_ASRS : MN_LSRS;
            res.immediate = (imm5 != 5'd0) ? {5'd0, imm5} : 10'd32;
         end else begin
            res.mnemonic = hw[9] ? MN_SUBS : MN_ADDS;
            if (hw[10]) res.immediate = {7'd0, hw[8:6]};
            else res.src_reg_b = {1'b0, hw[8:6]};
         end
      end else if (hw[15:13] == 3'b001) begin
         res.immediate = {2'd0, hw[7:0]};
         case (hw[12:11])
            2'd0: begin
               res.mnemonic = MN_MOVS;
               res.dest_reg = {1'b0, hw[10:8]};
            end
            2'd1: begin
               res.mnemonic  = MN_CMP;
               res.src_reg_a = {1'b0, hw[10:8]};
            end
            default: begin
               res.mnemonic  = hw[11] ? MN_SUBS : MN_ADDS;
               res.dest_reg  = {1'b0, hw[10:8]};
               res.src_reg_a = {1'b0, hw[10:8]};
            end
         endcase
      end else if (hw[15:10] == 6'b010000) begin
         res.mnemonic = dp_code(hw[9:6]);
         if (hw[9:6] == 4'd8 || hw[9:6] == 4'd10 || hw[9:6] == 4'd11) begin
            res.src_reg_a = {1'b0, hw[2:0]};
            res.src_reg_b = {1'b0, hw[5:3]};
         end else if (hw[9:6] == 4'd9 || hw[9:6] == 4'd15) begin
            res.dest_reg  = {1'b0, hw[2:0]};
            res.src_reg_a = {1'b0, hw[5:3]};
         end else if (hw[9:6] == 4'd13) begin
            res.dest_reg  = {1'b0, hw[2:0]};
            res.src_reg_a = {1'b0, hw[5:3]};
            res.src_reg_b = {1'b0, hw[2:0]};
         end else begin
            res.dest_reg  = {1'b0, hw[2:0]};
            res.src_reg_a = {1'b0, hw[2:0]};
            res.src_reg_b = {1'b0, hw[5:3]};
         end
      end else if (hw[15:10] == 6'b010001) begin
         case (hw[9:8])
            2'd0: begin
               res.mnemonic  = MN_ADD;
               res.dest_reg  = {hw[7], hw[2:0]};
               res.src_reg_a = {hw[7], hw[2:0]};
               res.src_reg_b = hw[6:3];
            end
            2'd1: begin
               res.mnemonic  = MN_CMP;
               res.src_reg_a = {hw[7], hw[2:0]};
               res.src_reg_b = hw[6:3];
            end
            2'd2: begin
               res.mnemonic  = MN_MOV;
               res.dest_reg  = {hw[7], hw[2:0]};
               res.src_reg_a = hw[6:3];
            end
            default: begin
               res.mnemonic  = hw[7] ? MN_BLX : MN_BX;
               res.src_reg_a = hw[6:3];
            end
         endcase
      end else if (hw[15:11] == 5'b01001) begin
         res.mnemonic    = MN_LDR;
         res.dest_reg    = {1'b0, hw[10:8]};
         res.src_reg_a   = REG_PC;
         res.immediate   = {hw[7:0], 2'b00};
         res.target_addr = lit;
      end else if (hw[15:12] == 4'b0101) begin
         res.mnemonic  = lsreg_code(hw[11:9]);
         res.src_reg_b = {1'b0, hw[8:6]};
         res.src_reg_a = {1'b0, hw[5:3]};
         res.dest_reg  = {1'b0, hw[2:0]};
      end else if (hw[15:13] == 3'b011) begin
         if (hw[11]) res.mnemonic = hw[12] ? MN_LDRB : MN_LDR;
         else res.mnemonic = hw[12] ? MN_STRB : MN_STR;
         res.immediate = hw[12] ? {5'd0, imm5} : {3'd0, imm5, 2'b00};
         res.src_reg_a = {1'b0, hw[5:3]};
         res.dest_reg  = {1'b0, hw[2:0]};
      end else if (hw[15:12] == 4'b1000) begin
         res.mnemonic  = hw[11] ? MN_LDRH : MN_STRH;
         res.immediate = {4'd0, imm5, 1'b0};
         res.src_reg_a = {1'b0, hw[5:3]};
         res.dest_reg  = {1'b0, hw[2:0]};
      end else if (hw[15:12] == 4'b1001) begin
         res.mnemonic  = hw[11] ? MN_LDR : MN_STR;
         res.dest_reg  = {1'b0, hw[10:8]};
         res.src_reg_a = REG_SP;
         res.immediate = {hw[7:0], 2'b00};
      end else if (hw[15:11] == 5'b10100) begin
         res.mnemonic    = MN_ADR;
         res.dest_reg    = {1'b0, hw[10:8]};
         res.src_reg_a   = REG_PC;
         res.immediate   = {hw[7:0], 2'b00};
         res.target_addr = lit;
      end else if (hw[15:11] == 5'b10101) begin
         res.mnemonic  = MN_ADD;
         res.dest_reg  = {1'b0, hw[10:8]};
         res.src_reg_a = REG_SP;
         res.immediate = {hw[7:0], 2'b00};
      end else if (hw[15:8] == 8'hb0) begin
         res.mnemonic  = hw[7] ? MN_SUB : MN_ADD;
         res.dest_reg  = REG_SP;
         res.src_reg_a = REG_SP;
         res.immediate = {1'b0, hw[6:0], 2'b00};
      end else if (hw[15:9] == 7'b1011010 || hw[15:9] == 7'b1011110) begin
         res.mnemonic  = hw[11] ? MN_POP : MN_PUSH;
         res.src_reg_a = REG_SP;
         res.reg_list  = hw[8:0];
      end else if (hw[15:8] == 8'hbe) begin
         res.mnemonic  = MN_BKPT;
         res.immediate = {2'd0, hw[7:0]};
      end else if (hw[15:8] == 8'hbf) begin
         if (mask == 4'd0) begin
            res.mnemonic = MN_HINT0 + {4'd0, fc[2:0]};
         end else begin
            res.mnemonic  = MN_IT;
            res.cond_code = fc;
            is_it         = 1'b1;
            // The lowest set mask bit marks the block length.
            if (mask[0]) begin
               res.it_length    = 3'd4;
               res.it_else_bits = {mask[1] ^ fc[0], mask[2] ^ fc[0], mask[3] ^ fc[0]};
            end else if (mask[1]) begin
               res.it_length    = 3'd3;
               res.it_else_bits = {1'b0, mask[2] ^ fc[0], mask[3] ^ fc[0]};
            end else if (mask[2]) begin
               res.it_length    = 3'd2;
               res.it_else_bits = {2'b00, mask[3] ^ fc[0]};
            end else begin
               res.it_length = 3'd1;
            end
         end
      end else if (hw[15:8] == 8'hb2) begin
         res.mnemonic  = MN_EXT0 + {5'd0, hw[7:6]};
         res.src_reg_a = {1'b0, hw[5:3]};
         res.dest_reg  = {1'b0, hw[2:0]};
      end else if (hw[15:12] == 4'b1100) begin
         res.mnemonic  = hw[11] ? MN_LDMIA : MN_STMIA;
         res.src_reg_a = {1'b0, hw[10:8]};
         res.reg_list  = {1'b0, hw[7:0]};
      end else if (hw[15:12] == 4'b1101) begin
         if (hw[11:8] == 4'he) begin
            res.mnemonic  = MN_UDF;
            res.immediate = {2'd0, hw[7:0]};
         end else if (hw[11:8] == 4'hf) begin
            res.mnemonic  = MN_SVC;
            res.immediate = {2'd0, hw[7:0]};
         end else begin
            res.mnemonic    = MN_B;
            res.cond_code   = hw[11:8];
            res.target_addr = pc4 + {{23{hw[7]}}, hw[7:0], 1'b0};
         end
      end else if (hw[15:11] == 5'b11100) begin
         res.mnemonic    = MN_B;
         res.target_addr = pc4 + {{20{hw[10]}}, hw[10:0], 1'b0};
      end else begin
         res.recognized = 1'b0;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/thumb16_instruction_decoder.sv =====
`default_nettype none
// Thumb 16-bit instruction decoder. One request (halfword and its address) is
// accepted per cycle while the result register is empty or being drained, and
// its decoded fields appear on the rsp_ port from the result register in the
// cycle after it is taken. The IT-block state is updated at each accepted
// request, so consecutive halfwords of one fetch stream decode back to back.
module thumb16_instruction_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_halfword,
   input  wire logic [31:0] req_pc_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_mnemonic,
   output logic [3:0]       rsp_dest_reg,
   output logic [3:0]       rsp_src_reg_a,
   output logic [3:0]       rsp_src_reg_b,
   output logic [9:0]       rsp_immediate,
   output logic [31:0]      rsp_target_addr,
   output logic [8:0]       rsp_reg_list,
   output logic [3:0]       rsp_cond_code,
   output logic             rsp_cond_active,
   output logic [2:0]       rsp_it_length,
   output logic [2:0]       rsp_it_else_bits,
   output logic             rsp_recognized
);
   import t16dec_pkg::*;

   logic [7:0] it_ff, it_in;
   logic       valid_ff;
   result_type res_ff, dec;
   logic       is_it;
   logic       take;

   assign req_ready = !valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   t16dec_decode u_decode (
      .hw       (req_halfword),
      .pc       (req_pc_addr),
      .it_state (it_ff),
      .res      (dec),
      .is_it    (is_it)
   );

   // IT state: load on IT, otherwise advance while inside a block.
   always_comb begin
      it_in = it_ff;
      if (is_it) it_in = req_halfword[7:0];
      else if (it_ff[3:0] != 4'd0) begin
         if (it_ff[2:0] != 3'd0) it_in = {it_ff[7:5], it_ff[3:0], 1'b0};
         else it_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         it_ff    <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         if (take) it_ff <= it_in;
         if (take) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (take) res_ff <= dec;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_mnemonic     = res_ff.mnemonic;
   assign rsp_dest_reg     = res_ff.dest_reg;
   assign rsp_src_reg_a    = res_ff.src_reg_a;
   assign rsp_src_reg_b    = res_ff.src_reg_b;
   assign rsp_immediate    = res_ff.immediate;
   assign rsp_target_addr  = res_ff.target_addr;
   assign rsp_reg_list     = res_ff.reg_list;
   assign rsp_cond_code    = res_ff.cond_code;
   assign rsp_cond_active  = res_ff.cond_active;
   assign rsp_it_length    = res_ff.it_length;
   assign rsp_it_else_bits = res_ff.it_else_bits;
   assign rsp_recognized   = res_ff.recognized;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import t16dec_pkg::*;

   localparam int STALL_MAX  = 18;
   localparam int IDLE_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_halfword;
   logic [31:0] req_pc_addr;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [6:0]  rsp_mnemonic;
   logic [3:0]  rsp_dest_reg;
   logic [3:0]  rsp_src_reg_a;
   logic [3:0]  rsp_src_reg_b;
   logic [9:0]  rsp_immediate;
   logic [31:0] rsp_target_addr;
   logic [8:0]  rsp_reg_list;
   logic [3:0]  rsp_cond_code;
   logic        rsp_cond_active;
   logic [2:0]  rsp_it_length;
   logic [2:0]  rsp_it_else_bits;
   logic        rsp_recognized;

   logic [6:0] alu_mnemonics [16];
   logic [6:0] ldst_mnemonics [8];
   logic [7:0] it_block_state;
   result_type expected_decodes [$];
   int         error_count;
   int         idle_cycles;
   bit         no_idle;
   int         rsp_hold_cycles;

   thumb16_instruction_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_halfword     (req_halfword),
      .req_pc_addr      (req_pc_addr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mnemonic     (rsp_mnemonic),
      .rsp_dest_reg     (rsp_dest_reg),
      .rsp_src_reg_a    (rsp_src_reg_a),
      .rsp_src_reg_b    (rsp_src_reg_b),
      .rsp_immediate    (rsp_immediate),
      .rsp_target_addr  (rsp_target_addr),
      .rsp_reg_list     (rsp_reg_list),
      .rsp_cond_code    (rsp_cond_code),
      .rsp_cond_active  (rsp_cond_active),
      .rsp_it_length    (rsp_it_length),
      .rsp_it_else_bits (rsp_it_else_bits),
      .rsp_recognized   (rsp_recognized)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Decode one halfword and advance the IT-block state as the block should.
   function automatic result_type decode_halfword(logic [15:0] hw, logic [31:0] pc);
      result_type r;
      logic       active;
      logic       is_it;
      logic [31:0] lit_addr;
      logic [3:0] rdn;
      logic [3:0] fc;
      logic [3:0] mask;
      int         tpos;
      r = '0;
      r.mnemonic = MN_UNKNOWN;
      r.recognized = 1'b1;
      active = it_block_state[3:0] != 4'd0;
      r.cond_active = active;
      r.cond_code = active ? it_block_state[7:4] : COND_AL;
      is_it = 1'b0;
      lit_addr = {pc[31:2], 2'b00} + 32'd4 + {22'd0, hw[7:0], 2'b00};
      if (hw[15:13] == 3'b000) begin
         // Shift by immediate and add/subtract with a third register or a 3-bit immediate.
         r.dest_reg = {1'b0, hw[2:0]};
         r.src_reg_a = {1'b0, hw[5:3]};
         if (hw[12:11] == 2'b00) begin
            r.mnemonic = (hw[10:6] != 5'd0) ? MN_LSLS : MN_MOVS;
            r.immediate = {5'd0, hw[10:6]};
         end else if (hw[12:11] != 2'b11) begin
            r.mnemonic = (hw[12:11] == 2'b01) ? MN_LSRS : MN_ASRS;
            r.immediate = (hw[10:6] != 5'd0) ? {5'd0, hw[10:6]} : 10'd32;
         end else begin
            r.mnemonic = hw[9] ? MN_SUBS : MN_ADDS;
            if (hw[10]) begin
               r.immediate = {7'd0, hw[8:6]};
            end else begin
               r.src_reg_b = {1'b0, hw[8:6]};
            end
         end
      end else if (hw[15:13] == 3'b001) begin
         r.immediate = {2'd0, hw[7:0]};
         case (hw[12:11])
            2'd0: begin
               r.mnemonic = MN_MOVS;
               r.dest_reg = {1'b0, hw[10:8]};
            end
            2'd1: begin
               r.mnemonic = MN_CMP;
               r.src_reg_a = {1'b0, hw[10:8]};
            end
            default: begin
               r.mnemonic = (hw[11]) ? MN_SUBS : MN_ADDS;
               r.dest_reg = {1'b0, hw[10:8]};
               r.src_reg_a = {1'b0, hw[10:8]};
            end
         endcase
      end else if (hw[15:10] == 6'b010000) begin
         // Two-register data processing.
         r.mnemonic = alu_mnemonics[hw[9:6]];
         case (hw[9:6])
            4'd8, 4'd10, 4'd11: begin
               r.src_reg_a = {1'b0, hw[2:0]};
               r.src_reg_b = {1'b0, hw[5:3]};
            end
            4'd9, 4'd15: begin
               r.dest_reg = {1'b0, hw[2:0]};
               r.src_reg_a = {1'b0, hw[5:3]};
            end
            4'd13: begin
               r.dest_reg = {1'b0, hw[2:0]};
               r.src_reg_a = {1'b0, hw[5:3]};
               r.src_reg_b = {1'b0, hw[2:0]};
            end
            default: begin
               r.dest_reg = {1'b0, hw[2:0]};
               r.src_reg_a = {1'b0, hw[2:0]};
               r.src_reg_b = {1'b0, hw[5:3]};
            end
         endcase
      end else if (hw[15:10] == 6'b010001) begin
         // High-register operations and branch-exchange.
         rdn = {hw[7], hw[2:0]};
         case (hw[9:8])
            2'd0: begin
               r.mnemonic = MN_ADD;
               r.dest_reg = rdn;
               r.src_reg_a = rdn;
               r.src_reg_b = hw[6:3];
            end
            2'd1: begin
               r.mnemonic = MN_CMP;
               r.src_reg_a = rdn;
               r.src_reg_b = hw[6:3];
            end
            2'd2: begin
               r.mnemonic = MN_MOV;
               r.dest_reg = rdn;
               r.src_reg_a = hw[6:3];
            end
            default: begin
               r.mnemonic = hw[7] ? MN_BLX : MN_BX;
               r.src_reg_a = hw[6:3];
            end
         endcase
      end else if (hw[15:11] == 5'b01001) begin
         r.mnemonic = MN_LDR;
         r.dest_reg = {1'b0, hw[10:8]};
         r.src_reg_a = REG_PC;
         r.immediate = {hw[7:0], 2'b00};
         r.target_addr = lit_addr;
      end else if (hw[15:12] == 4'b0101) begin
         r.mnemonic = ldst_mnemonics[hw[11:9]];
         r.src_reg_b = {1'b0, hw[8:6]};
         r.src_reg_a = {1'b0, hw[5:3]};
         r.dest_reg = {1'b0, hw[2:0]};
      end else if (hw[15:13] == 3'b011) begin
         if (hw[11]) begin
            r.mnemonic = hw[12] ? MN_LDRB : MN_LDR;
         end else begin
            r.mnemonic = hw[12] ? MN_STRB : MN_STR;
         end
         r.immediate = hw[12] ? {5'd0, hw[10:6]} : {3'd0, hw[10:6], 2'b00};
         r.src_reg_a = {1'b0, hw[5:3]};
         r.dest_reg = {1'b0, hw[2:0]};
      end else if (hw[15:12] == 4'b1000) begin
         r.mnemonic = hw[11] ? MN_LDRH : MN_STRH;
         r.immediate = {4'd0, hw[10:6], 1'b0};
         r.src_reg_a = {1'b0, hw[5:3]};
         r.dest_reg = {1'b0, hw[2:0]};
      end else if (hw[15:12] == 4'b1001) begin
         r.mnemonic = hw[11] ? MN_LDR : MN_STR;
         r.dest_reg = {1'b0, hw[10:8]};
         r.src_reg_a = REG_SP;
         r.immediate = {hw[7:0], 2'b00};
      end else if (hw[15:11] == 5'b10100) begin
         r.mnemonic = MN_ADR;
         r.dest_reg = {1'b0, hw[10:8]};
         r.src_reg_a = REG_PC;
         r.immediate = {hw[7:0], 2'b00};
         r.target_addr = lit_addr;
      end else if (hw[15:11] == 5'b10101) begin
         r.mnemonic = MN_ADD;
         r.dest_reg = {1'b0, hw[10:8]};
         r.src_reg_a = REG_SP;
         r.immediate = {hw[7:0], 2'b00};
      end else if (hw[15:8] == 8'hb0) begin
         r.mnemonic = hw[7] ? MN_SUB : MN_ADD;
         r.dest_reg = REG_SP;
         r.src_reg_a = REG_SP;
         r.immediate = {1'b0, hw[6:0], 2'b00};
      end else if (hw[15:9] == 7'b1011010 || hw[15:9] == 7'b1011110) begin
         r.mnemonic = hw[11] ? MN_POP : MN_PUSH;
         r.src_reg_a = REG_SP;
         r.reg_list = hw[8:0];
      end else if (hw[15:8] == 8'hbe) begin
         r.mnemonic = MN_BKPT;
         r.immediate = {2'd0, hw[7:0]};
      end else if (hw[15:8] == 8'hbf) begin
         // Hints when the mask is empty, otherwise IT.
         fc = hw[7:4];
         mask = hw[3:0];
         if (mask == 4'd0) begin
            r.mnemonic = MN_HINT0 + {4'd0, fc[2:0]};
         end else begin
            tpos = 0;
            while (mask[tpos] == 1'b0) tpos++;
            r.mnemonic = MN_IT;
            r.cond_code = fc;
            r.it_length = 3'(4 - tpos);
            for (int k = 0; k < 3 - tpos; k++) begin
               if (mask[3 - k] != fc[0]) r.it_else_bits[k] = 1'b1;
            end
            is_it = 1'b1;
         end
      end else if (hw[15:8] == 8'hb2) begin
         r.mnemonic = MN_EXT0 + {5'd0, hw[7:6]};
         r.src_reg_a = {1'b0, hw[5:3]};
         r.dest_reg = {1'b0, hw[2:0]};
      end else if (hw[15:12] == 4'b1100) begin
         r.mnemonic = hw[11] ? MN_LDMIA : MN_STMIA;
         r.src_reg_a = {1'b0, hw[10:8]};
         r.reg_list = {1'b0, hw[7:0]};
      end else if (hw[15:12] == 4'b1101) begin
         if (hw[11:8] == 4'he) begin
            r.mnemonic = MN_UDF;
            r.immediate = {2'd0, hw[7:0]};
         end else if (hw[11:8] == 4'hf) begin
            r.mnemonic = MN_SVC;
            r.immediate = {2'd0, hw[7:0]};
         end else begin
            r.mnemonic = MN_B;
            r.cond_code = hw[11:8];
            r.target_addr = pc + 32'd4 + {{23{hw[7]}}, hw[7:0], 1'b0};
         end
      end else if (hw[15:11] == 5'b11100) begin
         r.mnemonic = MN_B;
         r.target_addr = pc + 32'd4 + {{20{hw[10]}}, hw[10:0], 1'b0};
      end else begin
         r.recognized = 1'b0;
      end
      // An IT reloads the state; anything else steps through the open block.
      if (is_it) begin
         it_block_state = hw[7:0];
      end else if (active) begin
         if (it_block_state[2:0] != 3'd0) begin
            it_block_state = {it_block_state[7:5], it_block_state[3:0], 1'b0};
         end else begin
            it_block_state = 8'd0;
         end
      end
      return r;
   endfunction

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, STALL_MAX);
   endfunction

   // Offer one request, wait for it to be taken and record its expected decode.
   task automatic send_request(logic [15:0] hw, logic [31:0] pc);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_halfword <= hw;
      req_pc_addr <= pc;
      do @(posedge clock); while (!(req_valid && req_ready));
      expected_decodes.push_back(decode_halfword(hw, pc));
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Receiving side: random stalls, an occasional long hold-off, field checks.
   initial begin
      int         stall;
      result_type want;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = draw_wait();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if (expected_decodes.size() == 0) begin
            $error("decode result arrived with no request outstanding");
            error_count++;
         end else begin
            want = expected_decodes.pop_front();
            check_field("mnemonic", 32'(want.mnemonic), 32'(rsp_mnemonic));
            check_field("dest_reg", 32'(want.dest_reg), 32'(rsp_dest_reg));
            check_field("src_reg_a", 32'(want.src_reg_a), 32'(rsp_src_reg_a));
            check_field("src_reg_b", 32'(want.src_reg_b), 32'(rsp_src_reg_b));
            check_field("immediate", 32'(want.immediate), 32'(rsp_immediate));
            check_field("target_addr", want.target_addr, rsp_target_addr);
            check_field("reg_list", 32'(want.reg_list), 32'(rsp_reg_list));
            check_field("cond_code", 32'(want.cond_code), 32'(rsp_cond_code));
            check_field("cond_active", 32'(want.cond_active), 32'(rsp_cond_active));
            check_field("it_length", 32'(want.it_length), 32'(rsp_it_length));
            check_field("it_else_bits", 32'(want.it_else_bits),
                        32'(rsp_it_else_bits));
            check_field("recognized", 32'(want.recognized), 32'(rsp_recognized));
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Corner encodings, address wrap and the IT special cases.
   task automatic test_directed();
      no_idle = 1'b0;
      send_request(16'h0000, 32'h0000_0000);
      send_request(16'h07ff, 32'hffff_ffff);
      send_request(16'h0800, 32'h0000_0000);
      send_request(16'h1000, 32'h0000_0000);
      send_request(16'h1bff, 32'h0000_0000);
      send_request(16'h1fff, 32'h0000_0000);
      send_request(16'h2fff, 32'h0000_0000);
      send_request(16'h3fff, 32'h0000_0000);
      send_request(16'h43ff, 32'h0000_0000);
      send_request(16'h47ff, 32'h0000_0000);
      send_request(16'h4fff, 32'hffff_ffff);
      send_request(16'h5fff, 32'h0000_0000);
      send_request(16'h7fff, 32'h0000_0000);
      send_request(16'ha7ff, 32'hffff_fffe);
      send_request(16'hb0ff, 32'h0000_0000);
      send_request(16'hb5ff, 32'h0000_0000);
      send_request(16'hbdff, 32'h0000_0000);
      send_request(16'hbeff, 32'h0000_0000);
      send_request(16'hb2ff, 32'h0000_0000);
      send_request(16'hdeff, 32'h0000_0000);
      send_request(16'hdfff, 32'h0000_0000);
      send_request(16'hd080, 32'h0000_0000);
      send_request(16'he400, 32'h0000_0000);
      send_request(16'he3ff, 32'hffff_fffc);
      // Hint with a high firstcond, then an IT with firstcond AL, reloaded mid-block.
      send_request(16'hbff0, 32'h0000_0000);
      send_request(16'hbfe1, 32'h0000_0000);
      send_request(16'hbf1f, 32'h0000_0000);
      send_request(16'hffff, 32'h0000_0000);
      send_request(16'hbff8, 32'h0000_0000);
      send_request(16'hd3fe, 32'h0000_1000);
   endtask

   // IT instructions followed by bodies of random length and content.
   task automatic test_it_blocks();
      int body;
      for (int n = 0; n < 130; n++) begin
         no_idle = (n % 40) >= 30;
         send_request({8'hbf, 4'($urandom_range(0, 15)), 4'($urandom_range(1, 15))},
                      $urandom());
         body = $urandom_range(0, 5);
         for (int i = 0; i < body; i++) begin
            send_request(16'($urandom()), $urandom());
         end
      end
   endtask

   task automatic test_random_stream();
      for (int n = 0; n < 1025; n++) begin
         no_idle = (n % 100) >= 75;
         send_request(16'($urandom()), $urandom());
      end
   endtask

   // The receiver stops for a long stretch while requests keep coming.
   task automatic test_backpressure();
      no_idle = 1'b1;
      rsp_hold_cycles = 120;
      for (int n = 0; n < 40; n++) begin
         send_request(16'($urandom()), $urandom());
      end
   endtask

   initial begin
      alu_mnemonics = '{MN_ANDS, MN_EORS, MN_LSLS, MN_LSRS, MN_ASRS, MN_ADCS,
                        MN_SBCS, MN_RORS, MN_TST, MN_RSBS, MN_CMP, MN_CMN,
                        MN_ORRS, MN_MULS, MN_BICS, MN_MVNS};
      ldst_mnemonics = '{MN_STR, MN_STRH, MN_STRB, MN_LDRSB, MN_LDR, MN_LDRH,
                         MN_LDRB, MN_LDRSH};
      it_block_state = 8'd0;
      error_count = 0;
      rsp_hold_cycles = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_halfword = 16'd0;
      req_pc_addr = 32'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_it_blocks();
      test_backpressure();
      test_random_stream();
      req_valid <= 1'b0;
      while (expected_decodes.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
